### rtl/sbst_pkg.sv
// shared widths, types and arithmetic helpers for the segment versus box slab test
`default_nettype none

package sbst_pkg;

    localparam int COORD_BITS = 16;
    localparam int POS_W      = COORD_BITS;
    localparam int DIR_W      = COORD_BITS + 1;
    localparam int EXT_W      = COORD_BITS - 1;
    localparam int DEN_W      = COORD_BITS + 1;
    localparam int NUM_W      = DEN_W + 1;
    localparam int PROD_W     = NUM_W + DEN_W + 1;

    // one axis reduced to entry and exit fractions over a shared non-negative denominator
    typedef struct packed {
        logic                    zero;
        logic                    pass;
        logic signed [NUM_W-1:0] en_num;
        logic signed [NUM_W-1:0] ex_num;
        logic [DEN_W-1:0]        den;
    } axis_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
    } frac_t;

    function automatic axis_t axis_prep(
        input logic signed [POS_W-1:0] o,
        input logic signed [DIR_W-1:0] d,
        input logic signed [POS_W-1:0] lo,
        input logic [EXT_W-1:0]        ext
    );
        axis_t                   r;
        logic signed [NUM_W-1:0] o_e;
        logic signed [NUM_W-1:0] lo_e;
        logic signed [NUM_W-1:0] hi_e;
        logic signed [NUM_W-1:0] a1;
        logic signed [NUM_W-1:0] a2;
        logic signed [NUM_W-1:0] d_e;
        logic signed [NUM_W-1:0] d_n;
        o_e    = NUM_W'(o);
        lo_e   = NUM_W'(lo);
        hi_e   = lo_e + $signed({{(NUM_W-EXT_W){1'b0}}, ext});
        a1     = lo_e - o_e;
        a2     = hi_e - o_e;
        d_e    = NUM_W'(d);
        d_n    = -d_e;
        r.zero = (d == '0);
        r.pass = (o_e >= lo_e) && (o_e <= hi_e);
        if (d_e[NUM_W-1]) begin
            r.en_num = -a2;
            r.ex_num = -a1;
            r.den    = d_n[DEN_W-1:0];
        end else begin
            r.en_num = a1;
            r.ex_num = a2;
            r.den    = d_e[DEN_W-1:0];
        end
        return r;
    endfunction

    // signed numerator times non-negative denominator, exact
    function automatic logic signed [PROD_W-1:0] cross_mul(
        input logic signed [NUM_W-1:0] num,
        input logic [DEN_W-1:0]        den
    );
        logic signed [PROD_W-1:0] a;
        logic signed [PROD_W-1:0] b;
        a = PROD_W'(num);
        b = PROD_W'($signed({1'b0, den}));
        return a * b;
    endfunction

endpackage

`default_nettype wire

### rtl/segment_box_slab_test_unit.sv
// segment versus axis-aligned rectangle slab test, five stage pipeline
// a word passes stage registers 1 to 5 in order; out_valid is the stage 5 valid bit
// throughput: one word per cycle; the pipeline stalls only when out_ready is low
// and every stage holds a word; empty stages fill while the output waits
// stage 2 and stage 4 each hold the cross-multipliers that set the clock period
// reset clears only the stage valid bits; data registers are left unreset
`default_nettype none

module segment_box_slab_test_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [sbst_pkg::POS_W-1:0]    origin_x,
    input  wire logic signed [sbst_pkg::POS_W-1:0]    origin_y,
    input  wire logic signed [sbst_pkg::DIR_W-1:0]    dir_x,
    input  wire logic signed [sbst_pkg::DIR_W-1:0]    dir_y,
    input  wire logic signed [sbst_pkg::POS_W-1:0]    box_left,
    input  wire logic signed [sbst_pkg::POS_W-1:0]    box_top,
    input  wire logic [sbst_pkg::EXT_W-1:0]           box_width,
    input  wire logic [sbst_pkg::EXT_W-1:0]           box_height,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      hit
);

    // stage valid bits and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // stage 1: per axis fractions
    sbst_pkg::axis_t s1_x_reg, s1_y_reg;
    sbst_pkg::axis_t s1_x_next, s1_y_next;

    // stage 2: cross products of entries and exits
    sbst_pkg::axis_t                        s2_x_reg, s2_y_reg;
    logic                                   s2_dead_reg, s2_dead_next;
    logic signed [sbst_pkg::PROD_W-1:0]     s2_en_yx_reg, s2_en_xy_reg;
    logic signed [sbst_pkg::PROD_W-1:0]     s2_ex_yx_reg, s2_ex_xy_reg;

    // stage 3: overall entry and exit
    sbst_pkg::frac_t s3_tmin_reg, s3_tmax_reg, s3_tmin_next, s3_tmax_next;
    logic            s3_dead_reg;

    // stage 4: final cross products and range checks
    logic signed [sbst_pkg::PROD_W-1:0] s4_pmax_reg, s4_pmin_reg;
    logic                               s4_ok_reg, s4_ok_next;

    // stage 5: result
    logic s5_hit_reg, s5_hit_next;

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign out_valid = v5_reg;
    assign hit       = s5_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // stage 1 logic
    always_comb
    begin
        s1_x_next = sbst_pkg::axis_prep(origin_x, dir_x, box_left, box_width);
        s1_y_next = sbst_pkg::axis_prep(origin_y, dir_y, box_top, box_height);
    end

    // stage 2 logic: an axis with zero direction rejects unless the origin is in its slab;
    // both axes zero also rejects
    always_comb
    begin
        s2_dead_next = (s1_x_reg.zero && !s1_x_reg.pass) ||
                       (s1_y_reg.zero && !s1_y_reg.pass) ||
                       (s1_x_reg.zero && s1_y_reg.zero);
    end

    // stage 3 logic: largest entry, smallest exit; a zero axis contributes nothing
    always_comb
    begin
        logic en_y_gt;
        logic ex_y_lt;
        en_y_gt = s2_en_yx_reg > s2_en_xy_reg;
        ex_y_lt = s2_ex_yx_reg < s2_ex_xy_reg;
        s3_tmin_next.num = s2_x_reg.en_num;
        s3_tmin_next.den = s2_x_reg.den;
        s3_tmax_next.num = s2_x_reg.ex_num;
        s3_tmax_next.den = s2_x_reg.den;
        if (s2_x_reg.zero || (!s2_y_reg.zero && en_y_gt))
        begin
            s3_tmin_next.num = s2_y_reg.en_num;
            s3_tmin_next.den = s2_y_reg.den;
        end
        if (s2_x_reg.zero || (!s2_y_reg.zero && ex_y_lt))
        begin
            s3_tmax_next.num = s2_y_reg.ex_num;
            s3_tmax_next.den = s2_y_reg.den;
        end
    end

    // stage 4 logic: entry within [0,1]
    always_comb
    begin
        s4_ok_next = !s3_dead_reg && !s3_tmin_reg.num[sbst_pkg::NUM_W-1] &&
                     (s3_tmin_reg.num <= $signed({1'b0, s3_tmin_reg.den}));
    end

    // stage 5 logic: exit not below entry
    always_comb
    begin
        s5_hit_next = s4_ok_reg && (s4_pmax_reg >= s4_pmin_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            s1_x_reg <= s1_x_next;
            s1_y_reg <= s1_y_next;
        end
        if (rdy2 && v1_reg)
        begin
            s2_x_reg     <= s1_x_reg;
            s2_y_reg     <= s1_y_reg;
            s2_dead_reg  <= s2_dead_next;
            s2_en_yx_reg <= sbst_pkg::cross_mul(s1_y_reg.en_num, s1_x_reg.den);
            s2_en_xy_reg <= sbst_pkg::cross_mul(s1_x_reg.en_num, s1_y_reg.den);
            s2_ex_yx_reg <= sbst_pkg::cross_mul(s1_y_reg.ex_num, s1_x_reg.den);
            s2_ex_xy_reg <= sbst_pkg::cross_mul(s1_x_reg.ex_num, s1_y_reg.den);
        end
        if (rdy3 && v2_reg)
        begin
            s3_tmin_reg <= s3_tmin_next;
            s3_tmax_reg <= s3_tmax_next;
            s3_dead_reg <= s2_dead_reg;
        end
        if (rdy4 && v3_reg)
        begin
            s4_pmax_reg <= sbst_pkg::cross_mul(s3_tmax_reg.num, s3_tmin_reg.den);
            s4_pmin_reg <= sbst_pkg::cross_mul(s3_tmin_reg.num, s3_tmax_reg.den);
            s4_ok_reg   <= s4_ok_next;
        end
        if (rdy5 && v4_reg)
        begin
            s5_hit_reg <= s5_hit_next;
        end
    end

    // input is refused only when every stage holds a word and the output is stalled
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && !out_ready))
        else $error("input blocked while a pipeline stage is empty");

    // a word in stage 1 moves on when stage 2 can take it
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && rdy2) |=> v2_reg)
        else $error("word lost between stage 1 and stage 2");

    // a stalled middle stage keeps its word and its data
    a_hold_s3: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !rdy3) |=> (v3_reg && $stable(s3_tmin_reg) && $stable(s3_tmax_reg)
                               && $stable(s3_dead_reg)))
        else $error("stage 3 changed while stalled");

endmodule

`default_nettype wire
